// ===== design/swm_pkg.sv =====
`default_nettype none
package swm_pkg;

  // window length and sample width
  localparam int WINDOW   = 9;
  localparam int SAMPLE_W = 16;
  localparam int AGE_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID      = WINDOW / 2;

  localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(WINDOW - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AGE_W-1:0]    age_t;

  // what a cell shows to its neighbors and to the top level
  typedef struct packed {
    sample_t value;   // stored sample
    age_t    age;     // items since this sample arrived
    logic    lt;      // value < incoming sample
    logic    oldest;  // this sample leaves on the next item
  } cell_view_t;

  // boundary seen below cell 0 (ranks below everything)
  localparam cell_view_t BOUND_LO = '{value: '0, age: '0, lt: 1'b1, oldest: 1'b0};
  // boundary seen above the last cell (ranks above everything)
  localparam cell_view_t BOUND_HI = '{value: '0, age: '0, lt: 1'b0, oldest: 1'b0};

endpackage
`default_nettype wire

// ===== design/sliding_window_median.sv =====
`default_nettype none
// Sliding-window median over the last WINDOW samples (swm_pkg).
//
// Input channel: sample / sample_valid / sample_ready. Output channel:
// median / median_valid / median_ready. Every accepted item yields exactly
// one median, the value at rank WINDOW/2 of the window sorted ascending
// (upper median for an even window).
//
// The window lives in a row of cells kept in sorted order, each holding one
// sample and its age. On an accepted item every cell compares the new sample
// with its own value and, together with its two neighbors, drops the oldest
// sample and opens a slot for the new one in the same cycle.
//
// The median is registered: it appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver keeps up, as all cells update together.
// The result sits in the middle cell, which doubles as the output register:
// while the receiver stalls, sample_ready stays low and the window holds.
// Reset clears every sample to zero (ages 0..WINDOW-1) and drops any pending
// median; zeros take part in the ranking until WINDOW items have arrived.
module sliding_window_median import swm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire sample_t sample,
  input  wire logic    sample_valid,
  output logic         sample_ready,
  output sample_t      median,
  output logic         median_valid,
  input  wire logic    median_ready
);

  cell_view_t        views  [WINDOW];
  logic [WINDOW-1:0] oldest_vec;
  logic [WINDOW-1:0] kle;
  logic              load;

  // handshake: the window advances only when the output slot frees up
  assign sample_ready = !median_valid || median_ready;
  assign load         = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (load) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  // cell row
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_view_t left_v;
    cell_view_t right_v;
    logic       kle_left;

    assign oldest_vec[i] = views[i].oldest;
    // leaving sample at or below this cell
    assign kle[i] = |oldest_vec[i:0];

    if (i == 0) begin : g_lo
      assign left_v   = BOUND_LO;
      assign kle_left = 1'b0;
    end else begin : g_mid
      assign left_v   = views[i-1];
      assign kle_left = kle[i-1];
    end

    if (i == WINDOW - 1) begin : g_hi
      assign right_v = BOUND_HI;
    end else begin : g_nx
      assign right_v = views[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .init_age  (age_t'(i)),
      .load      (load),
      .sample_in (sample),
      .kle_self  (kle[i]),
      .kle_left  (kle_left),
      .left      (left_v),
      .right     (right_v),
      .view      (views[i])
    );
  end

  assign median = views[MID].value;

  // ordering check across neighboring cells
  logic [WINDOW-1:0] sorted_ok;
  for (genvar i = 0; i < WINDOW; i++) begin : g_chk
    if (i == WINDOW - 1) begin : g_last
      assign sorted_ok[i] = 1'b1;
    end else begin : g_pair
      assign sorted_ok[i] = (views[i].value <= views[i+1].value);
    end
  end

  // exactly one sample is due to leave
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    $countones(oldest_vec) == 1)
    else $error("window must hold exactly one oldest sample");

  // the cell row stays sorted
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &sorted_ok)
    else $error("cell row lost ascending order");

  // every accepted item leaves a median pending
  a_result: assert property (@(posedge clk) disable iff (rst)
    load |=> median_valid)
    else $error("accepted item produced no median");

  // no median pending right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !median_valid)
    else $error("median pending after reset");

endmodule
`default_nettype wire

// ===== design/swm_cell.sv =====
`default_nettype none
module swm_cell import swm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire age_t       init_age,   // age given at reset, distinct per cell
  input  wire logic       load,       // an item is accepted this cycle
  input  wire sample_t    sample_in,  // incoming item, broadcast to all cells
  input  wire logic       kle_self,   // leaving sample sits at or below this cell
  input  wire logic       kle_left,   // leaving sample sits at or below the left cell
  input  wire cell_view_t left,
  input  wire cell_view_t right,
  output cell_view_t      view
);

  sample_t value;
  age_t    age;

  sample_t value_next;
  age_t    age_next;

  // entries after the leaving sample is squeezed out
  sample_t up_value;
  age_t    up_age;
  logic    up_lt;
  sample_t lo_value;
  age_t    lo_age;
  logic    lo_lt;

  always_comb begin
    // own slot after removal: shift down from the right past the leaving sample
    up_value = kle_self ? right.value : value;
    up_age   = kle_self ? right.age   : age;
    up_lt    = kle_self ? right.lt    : view.lt;
    // slot below after removal
    lo_value = kle_left ? value   : left.value;
    lo_age   = kle_left ? age     : left.age;
    lo_lt    = kle_left ? view.lt : left.lt;

    // insertion: keep, take the new sample, or shift up from below
    if (up_lt) begin
      value_next = up_value;
      age_next   = up_age + age_t'(1);
    end else if (lo_lt) begin
      value_next = sample_in;
      age_next   = '0;
    end else begin
      value_next = lo_value;
      age_next   = lo_age + age_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= init_age;
    end else if (load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

  assign view.value  = value;
  assign view.age    = age;
  assign view.lt     = (value < sample_in);
  assign view.oldest = (age == OLDEST_AGE);

endmodule
`default_nettype wire
